FILE: rtl/bda_pkg.sv
package bda_pkg;

  localparam int MODE_W   = 3;
  localparam int PID_W    = 4;
  localparam int RID_W    = 3;
  localparam int AMOUNT_W = 16;
  localparam int STATUS_W = 3;
  localparam int SEQ_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [MODE_W-1:0] MODE_WR_ALLOC = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WR_CLAIM = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WR_AVAIL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WR_REQ   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CHECK    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SUBMIT   = 3'd5;

  localparam logic [STATUS_W-1:0] STS_SAFE       = 3'd0;
  localparam logic [STATUS_W-1:0] STS_UNSAFE     = 3'd1;
  localparam logic [STATUS_W-1:0] STS_OVER_CLAIM = 3'd2;
  localparam logic [STATUS_W-1:0] STS_UNAVAIL    = 3'd3;
  localparam logic [STATUS_W-1:0] STS_ACK        = 3'd4;
  localparam logic [STATUS_W-1:0] STS_BAD_IDX    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_PROC_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_COUNT  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_SUB_CHK,
    ST_SW_INIT,
    ST_SWEEP,
    ST_ROLLBACK,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/bda_ifs.sv
interface bda_in_if;
  import bda_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [PID_W-1:0]    proc_id;
  logic [RID_W-1:0]    res_id;
  logic [AMOUNT_W-1:0] amount;
  modport source (output valid, output mode, output proc_id, output res_id, output amount,
                  input ready);
  modport sink (input valid, input mode, input proc_id, input res_id, input amount,
                output ready);
endinterface

interface bda_out_if;
  import bda_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SEQ_W-1:0]    seq_proc;
  logic                last;
  modport source (output valid, output status, output seq_proc, output last, input ready);
  modport sink (input valid, input status, input seq_proc, input last, output ready);
endinterface

interface bda_cfg_if;
  import bda_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/bda_rowmem.sv
module bda_rowmem #(
  parameter int DEPTH = 16,
  parameter int LANES = 8,
  parameter int W     = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [LANES-1:0]                 wlane,
  input  logic [LANES-1:0][W-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [LANES-1:0][W-1:0]          rdata
);
  logic [LANES-1:0][W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]        row_vld;
  logic [LANES-1:0][W-1:0] rdata_q;
  logic                    rvld_q;

  // A row that was never written reads as zero; its first write fills all lanes.
  always_ff @(posedge clk) begin
    if (we) begin
      for (int l = 0; l < LANES; l++) begin
        if (wlane[l]) begin
          mem[waddr][l] <= wdata[l];
        end else if (!row_vld[waddr]) begin
          mem[waddr][l] <= '0;
        end
      end
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (we) begin
        row_vld[waddr] <= 1'b1;
      end
      rvld_q <= row_vld[raddr];
    end
  end

  assign rdata = rvld_q ? rdata_q : '0;
endmodule

FILE: rtl/bankers_deadlock_avoidance.sv
// Banker's deadlock-avoidance unit.
// Channels: item (input beats: mode, proc_id, res_id, amount), result (output
// beats: status, seq_proc, last) and cfg (register writes, always ready).
// Write items update the allocation or claim tables, the available vector or
// the request buffer and answer one beat: acknowledge, or bad index.
// A check item runs the safety sweep: one process row is compared against the
// work vector per cycle, limited by the single read port of the row memories.
// A safe result is proc_n beats, one per cycle while the receiver takes them,
// with last on the final one; an unsafe result is a single beat. A submit item
// first reads its rows for the claim test, then sweeps if that passes, and an
// unsafe grant is rolled back. The block takes one item at a time:
// item.ready is high only when idle, though a finished beat may still wait
// in the output register. When the receiver stalls, the pending beat holds
// and the block waits. Reset empties the output register, sets both counts
// to one and makes all tables read as zero at once, with no clearing pass.
module bankers_deadlock_avoidance #(
  parameter int MAX_PROCS  = 16,
  parameter int MAX_RES    = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  bda_cfg_if.sink   cfg,
  bda_in_if.sink    item,
  bda_out_if.source result
);
  import bda_pkg::*;

  localparam int PW = $clog2(MAX_PROCS);
  localparam int NW = $clog2(MAX_PROCS + 1);
  localparam int MW = $clog2(MAX_RES + 1);
  localparam int WW = COUNT_BITS + NW;

  typedef logic [MAX_RES-1:0][COUNT_BITS-1:0] row_t;

  state_t state, state_next;

  logic [4:0] process_count;
  logic [3:0] resource_count;
  logic [NW-1:0] proc_n;
  logic [MW-1:0] res_m;
  logic [MAX_RES-1:0] lane_used;

  logic          is_submit;
  logic [PW-1:0] pid_q;
  logic [STATUS_W-1:0] resp_status;
  row_t avail, reqv, saved_row;
  logic [MAX_RES-1:0][WW-1:0] work;
  logic [MAX_PROCS-1:0] finished;
  logic [NW-1:0] done_cnt;
  logic [PW-1:0] scan_idx, emit_idx;
  logic          progress;
  logic [PW-1:0] safe_order [MAX_PROCS];

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SEQ_W-1:0]    out_seq;
  logic                out_last;

  logic accept, slot_free, pid_ok, rid_ok;
  logic [COUNT_BITS-1:0] amt;
  logic [MAX_RES-1:0] rid_lane;

  logic [PW-1:0] raddr;
  row_t alloc_row, claim_row;
  logic alloc_we, claim_we;
  logic [PW-1:0] alloc_waddr;
  logic [MAX_RES-1:0] alloc_wlane, claim_wlane;
  row_t alloc_wdata, amt_row, granted_row;

  logic exceed, unavail, fits, take, row_last, sweep_done, emit_last;
  logic [PW-1:0] next_scan;
  logic resp_load;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count  <= 5'd1;
      resource_count <= 4'd1;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_PROC_COUNT) begin
        process_count <= cfg.data[4:0];
      end else if (cfg.index == CFG_RES_COUNT) begin
        resource_count <= cfg.data[3:0];
      end
    end
  end

  // Register values of zero count as one; values above the maxima saturate.
  always_comb begin
    if (process_count == '0) begin
      proc_n = NW'(1);
    end else if (int'(process_count) > MAX_PROCS) begin
      proc_n = NW'(MAX_PROCS);
    end else begin
      proc_n = NW'(process_count);
    end
    if (resource_count == '0) begin
      res_m = MW'(1);
    end else if (int'(resource_count) > MAX_RES) begin
      res_m = MW'(MAX_RES);
    end else begin
      res_m = MW'(resource_count);
    end
    for (int l = 0; l < MAX_RES; l++) begin
      lane_used[l] = l < int'(res_m);
      rid_lane[l]  = int'(item.res_id) == l;
    end
  end

  assign item.ready = state == ST_IDLE;
  assign accept     = item.valid && item.ready;
  assign slot_free  = !out_valid || result.ready;
  assign pid_ok     = int'(item.proc_id) < int'(proc_n);
  assign rid_ok     = int'(item.res_id) < int'(res_m);
  assign amt        = COUNT_BITS'(item.amount);

  always_comb begin
    for (int l = 0; l < MAX_RES; l++) begin
      amt_row[l] = amt;
    end
  end

  // Claim and availability test of a buffered request against the read row.
  always_comb begin
    exceed  = 1'b0;
    unavail = 1'b0;
    for (int l = 0; l < MAX_RES; l++) begin
      if (lane_used[l]) begin
        if ((COUNT_BITS+1)'(reqv[l]) + (COUNT_BITS+1)'(alloc_row[l])
            > (COUNT_BITS+1)'(claim_row[l])) begin
          exceed = 1'b1;
        end
        if (reqv[l] > avail[l]) begin
          unavail = 1'b1;
        end
        granted_row[l] = alloc_row[l] + reqv[l];
      end else begin
        granted_row[l] = alloc_row[l];
      end
    end
  end

  // One process row of the safety sweep. A negative need never blocks.
  always_comb begin
    fits = 1'b1;
    for (int l = 0; l < MAX_RES; l++) begin
      if (lane_used[l] && claim_row[l] > alloc_row[l]
          && WW'(claim_row[l] - alloc_row[l]) > work[l]) begin
        fits = 1'b0;
      end
    end
    take       = fits && !finished[scan_idx];
    row_last   = int'(scan_idx) + 1 == int'(proc_n);
    next_scan  = row_last ? '0 : scan_idx + PW'(1);
    sweep_done = take && (int'(done_cnt) + 1 == int'(proc_n));
    emit_last  = int'(emit_idx) + 1 == int'(proc_n);
  end

  always_comb begin
    state_next  = state;
    raddr       = '0;
    alloc_we    = 1'b0;
    alloc_waddr = pid_q;
    alloc_wlane = '1;
    alloc_wdata = granted_row;
    claim_we    = 1'b0;
    claim_wlane = rid_lane;
    resp_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        raddr = PW'(item.proc_id);
        if (accept) begin
          state_next = ST_RESP;
          case (item.mode)
            MODE_WR_ALLOC: begin
              alloc_we    = pid_ok && rid_ok;
              alloc_waddr = PW'(item.proc_id);
              alloc_wlane = rid_lane;
              alloc_wdata = amt_row;
            end
            MODE_WR_CLAIM: begin
              claim_we = pid_ok && rid_ok;
            end
            MODE_CHECK: begin
              state_next = ST_SW_INIT;
            end
            MODE_SUBMIT: begin
              if (pid_ok) begin
                state_next = ST_SUB_CHK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          resp_load  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SUB_CHK: begin
        if (exceed || unavail) begin
          state_next = ST_RESP;
        end else begin
          alloc_we   = 1'b1;
          state_next = ST_SW_INIT;
        end
      end
      ST_SW_INIT: begin
        state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        raddr = next_scan;
        if (sweep_done) begin
          state_next = ST_EMIT;
        end else if (row_last && !take && !progress) begin
          state_next = is_submit ? ST_ROLLBACK : ST_RESP;
        end
      end
      ST_ROLLBACK: begin
        alloc_we    = 1'b1;
        alloc_wdata = saved_row;
        state_next  = ST_RESP;
      end
      ST_EMIT: begin
        if (slot_free && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avail <= '0;
      reqv  <= '0;
    end else if (accept && rid_ok && item.mode == MODE_WR_AVAIL) begin
      avail[item.res_id] <= amt;
    end else if (accept && rid_ok && item.mode == MODE_WR_REQ) begin
      reqv[item.res_id] <= amt;
    end else if (state == ST_SUB_CHK && !exceed && !unavail) begin
      for (int l = 0; l < MAX_RES; l++) begin
        if (lane_used[l]) begin
          avail[l] <= avail[l] - reqv[l];
        end
      end
    end else if (state == ST_ROLLBACK) begin
      for (int l = 0; l < MAX_RES; l++) begin
        if (lane_used[l]) begin
          avail[l] <= avail[l] + reqv[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        pid_q     <= PW'(item.proc_id);
        is_submit <= item.mode == MODE_SUBMIT;
        case (item.mode)
          MODE_WR_ALLOC, MODE_WR_CLAIM: begin
            resp_status <= (pid_ok && rid_ok) ? STS_ACK : STS_BAD_IDX;
          end
          MODE_WR_AVAIL, MODE_WR_REQ: begin
            resp_status <= rid_ok ? STS_ACK : STS_BAD_IDX;
          end
          default: begin
            resp_status <= STS_BAD_IDX;
          end
        endcase
      end
      ST_SUB_CHK: begin
        saved_row   <= alloc_row;
        resp_status <= exceed ? STS_OVER_CLAIM : STS_UNAVAIL;
      end
      ST_SW_INIT: begin
        finished <= '0;
        done_cnt <= '0;
        scan_idx <= '0;
        progress <= 1'b0;
        emit_idx <= '0;
        for (int l = 0; l < MAX_RES; l++) begin
          work[l] <= WW'(avail[l]);
        end
      end
      ST_SWEEP: begin
        scan_idx    <= next_scan;
        resp_status <= STS_UNSAFE;
        if (take) begin
          finished[scan_idx] <= 1'b1;
          safe_order[done_cnt[PW-1:0]] <= scan_idx;
          done_cnt <= done_cnt + NW'(1);
          for (int l = 0; l < MAX_RES; l++) begin
            work[l] <= work[l] + WW'(alloc_row[l]);
          end
        end
        // A new pass starts with no progress recorded.
        progress <= row_last ? 1'b0 : (progress || take);
      end
      ST_EMIT: begin
        if (slot_free) begin
          emit_idx <= emit_idx + PW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_load || (state == ST_EMIT && slot_free)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_status <= resp_status;
      out_seq    <= '0;
      out_last   <= 1'b1;
    end else if (state == ST_EMIT && slot_free) begin
      out_status <= STS_SAFE;
      out_seq    <= SEQ_W'(safe_order[emit_idx]);
      out_last   <= emit_last;
    end
  end

  assign result.valid    = out_valid;
  assign result.status   = out_status;
  assign result.seq_proc = out_seq;
  assign result.last     = out_last;

  bda_rowmem #(.DEPTH(MAX_PROCS), .LANES(MAX_RES), .W(COUNT_BITS)) u_alloc (
    .clk   (clk),
    .rst   (rst),
    .we    (alloc_we),
    .waddr (alloc_waddr),
    .wlane (alloc_wlane),
    .wdata (alloc_wdata),
    .raddr (raddr),
    .rdata (alloc_row)
  );

  bda_rowmem #(.DEPTH(MAX_PROCS), .LANES(MAX_RES), .W(COUNT_BITS)) u_claim (
    .clk   (clk),
    .rst   (rst),
    .we    (claim_we),
    .waddr (PW'(item.proc_id)),
    .wlane (claim_wlane),
    .wdata (amt_row),
    .raddr (raddr),
    .rdata (claim_row)
  );
endmodule

FILE: rtl/bda_checker.sv
module bda_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [2:0] status,
  input logic [3:0] seq_proc,
  input logic       last
);
  import bda_pkg::*;

  // A pending beat is not withdrawn.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat withdrawn while stalled");

  // The block works on one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while the previous one is still in work");

  // Only safe-sequence beats can be followed by more beats of the same answer.
  a_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> status == STS_SAFE)
    else $error("non-final beat with a status other than safe");

  a_seq_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != STS_SAFE |-> seq_proc == '0)
    else $error("process index set on a non-sequence beat");
endmodule

bind bankers_deadlock_avoidance bda_checker u_bda_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .status       (result.status),
  .seq_proc     (result.seq_proc),
  .last         (result.last)
);
